@@ hw/rtl/astok_pkg.sv @@
// Shared types and constants for the assembly source tokenizer.
`timescale 1ns / 1ps
package astok_pkg;

   localparam int MaxText = 32;
   localparam int LenW = 6;
   localparam int AddrW = 5;

   typedef enum logic [3:0] {
      MODE_NEUTRAL = 4'd0,
      MODE_IDENT   = 4'd1,
      MODE_STRING  = 4'd2,
      MODE_DEC     = 4'd3,
      MODE_HEX     = 4'd4,
      MODE_WS      = 4'd5,
      MODE_OTHER   = 4'd6,
      MODE_SEMI    = 4'd7,
      MODE_WS_SEMI = 4'd8,
      MODE_STR_ESC = 4'd9
   } mode_type;

   typedef enum logic [3:0] {
      TOK_NEWLINE = 4'd0,
      TOK_COMMA   = 4'd1,
      TOK_EQUAL   = 4'd2,
      TOK_IDENT   = 4'd3,
      TOK_STRING  = 4'd4,
      TOK_INTEGER = 4'd5,
      TOK_SPACE   = 4'd6,
      TOK_OTHER   = 4'd7,
      TOK_ERROR   = 4'd8
   } tok_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_EVAL = 3'd1,
      ST_EMIT = 3'd2,
      ST_TEXT = 3'd3
   } state_type;

   // result of one evaluation pass of the lexer over the held item
   typedef struct packed {
      logic      emit;       // one simple token to put out
      logic      emit_text;  // stream buffered text
      logic      done;       // item consumed after this pass
      logic      run_end;    // no further result follows for this item
      tok_kind_type kind;
      logic [1:0] nl_kind;
   } status_type;

   typedef struct packed {
      logic load;      // capture the input item
      logic step;      // commit the evaluated pass
      logic text_adv;  // advance the text read pointer
      logic text_start;
   } command_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [1:0]  newline_kind;
      logic [15:0] line;
      logic [15:0] column;
      logic [31:0] int_value;
      logic [4:0]  register_number;
      logic [7:0]  text_byte;
      logic        text_valid;
      logic        text_truncated;
   } result_type;

endpackage

@@ hw/rtl/astok_ctrl.sv @@
// Sequencer that steps the lexer passes and the text readout for one item.
`timescale 1ns / 1ps
module astok_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  astok_pkg::status_type    status,
   input  logic                     text_last,
   input  logic                     out_free,
   output logic                     out_load,
   output logic                     out_tok_last,
   output logic                     out_run_last,
   output astok_pkg::command_type   cmd
);

   astok_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= astok_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         astok_pkg::ST_IDLE: begin
            if (in_valid) state_in = astok_pkg::ST_EVAL;
         end
         astok_pkg::ST_EVAL: begin
            if (status.emit_text) begin
               if (out_free) state_in = astok_pkg::ST_TEXT;
            end else if (status.emit) begin
               if (out_free && status.done) state_in = astok_pkg::ST_IDLE;
            end else if (status.done) begin
               state_in = astok_pkg::ST_IDLE;
            end
         end
         astok_pkg::ST_TEXT: begin
            if (out_free && text_last) begin
               state_in = status.done ? astok_pkg::ST_IDLE : astok_pkg::ST_EVAL;
            end
         end
         default: state_in = astok_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready     = 1'b0;
      out_load     = 1'b0;
      out_tok_last = 1'b0;
      out_run_last = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         astok_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         astok_pkg::ST_EVAL: begin
            if (status.emit_text) begin
               cmd.text_start = out_free;
            end else if (status.emit) begin
               out_load     = out_free;
               out_tok_last = 1'b1;
               out_run_last = status.run_end;
               cmd.step     = out_free;
            end else begin
               cmd.step = 1'b1;
            end
         end
         astok_pkg::ST_TEXT: begin
            out_load     = out_free;
            cmd.text_adv = out_free;
            out_tok_last = text_last;
            // the pass that emitted the text is committed on its last byte
            out_run_last = text_last && status.run_end;
            cmd.step     = out_free && text_last;
         end
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/astok_datapath.sv @@
// Lexer state, text buffer, number accumulator and result formatting.
`timescale 1ns / 1ps
module astok_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  astok_pkg::command_type   cmd,
   input  logic [7:0]               in_byte,
   input  logic                     in_end,
   input  logic [7:0]               in_next,
   input  logic                     in_next_end,
   output astok_pkg::status_type    status,
   output logic                     text_last,
   output astok_pkg::result_type    result
);

   logic [7:0]  c_ff, nb_ff;
   logic        eof_ff, neof_ff;
   astok_pkg::mode_type mode_ff, mode_in;
   logic [15:0] line_ff, line_in, col_ff, col_in, start_ff, start_in;
   logic [astok_pkg::LenW-1:0] len_ff, len_in, rd_ff;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in, ovf_ff, ovf_in;
   logic [7:0]  store_mem [astok_pkg::MaxText];
   logic        wr_en;
   logic [7:0]  rd_data_ff;
   logic [7:0]  g0_ff, r1_ff, d2_ff, d3_ff;
   logic [4:0]  reg_num;
   logic [15:0] tok_col;
   logic        c_digit, c_alpha, c_space, c_hex, c_word;
   logic [3:0]  digit;
   logic [35:0] prod;
   logic [31:0] mag_sum;
   logic [31:0] int_val;
   logic [15:0] line_inc, col_inc;

   assign line_inc = (line_ff == 16'hFFFF) ? line_ff : line_ff + 16'd1;
   assign col_inc  = (col_ff == 16'hFFFF) ? col_ff : col_ff + 16'd1;
   assign c_digit  = (c_ff >= "0") && (c_ff <= "9");
   assign c_alpha  = ((c_ff >= "a") && (c_ff <= "z")) || ((c_ff >= "A") && (c_ff <= "Z"));
   assign c_space  = (c_ff == " ") || ((c_ff >= 8'd9) && (c_ff <= 8'd13));
   assign c_hex    = c_digit || ((c_ff >= "A") && (c_ff <= "F"));
   assign c_word   = (c_ff == "_") || (c_ff == "@") || c_alpha;
   assign digit    = c_digit ? c_ff[3:0] : 4'(c_ff - "A" + 8'd10);
   assign prod     = (mode_ff == astok_pkg::MODE_HEX) ? {mag_ff, 4'd0}
                   : ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1);
   assign mag_sum  = (prod + 36'(digit) > 36'h80000000) ? 32'h80000000
                   : 32'(prod + 36'(digit));

   always_comb begin
      if (neg_ff) int_val = (mag_ff >= 32'h80000000) ? 32'h80000000 : 32'd0 - mag_ff;
      else        int_val = mag_ff[31] ? 32'h7FFFFFFF : mag_ff;
   end

   // one pass of the lexer
   always_comb begin
      status   = '0;
      status.kind = astok_pkg::TOK_NEWLINE;
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      start_in = start_ff;
      len_in   = len_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      wr_en    = 1'b0;
      tok_col  = start_ff;
      unique case (mode_ff)
         astok_pkg::MODE_NEUTRAL: begin
            tok_col = col_ff;
            start_in = col_ff;
            if (eof_ff || c_ff == 8'h0A) begin
               status.emit = 1'b1; status.done = 1'b1;
               line_in = line_inc; col_in = 16'd1;
            end else if (c_ff == "," || c_ff == "=") begin
               status.emit = 1'b1; status.done = 1'b1;
               status.kind = (c_ff == ",") ? astok_pkg::TOK_COMMA : astok_pkg::TOK_EQUAL;
               col_in = col_inc;
               start_in = start_ff;
            end else if (c_ff == ";" || c_ff == 8'h27 || c_ff == "#") begin
               mode_in = (c_ff == ";") ? astok_pkg::MODE_SEMI :
                         (c_ff == "#") ? astok_pkg::MODE_HEX : astok_pkg::MODE_STRING;
               len_in = '0; ovf_in = 1'b0; mag_in = '0; neg_in = 1'b0;
               col_in = col_inc; status.done = 1'b1;
            end else if (c_word) begin
               mode_in = astok_pkg::MODE_IDENT; len_in = '0; ovf_in = 1'b0;
            end else if (c_digit) begin
               mode_in = astok_pkg::MODE_DEC; mag_in = '0; neg_in = 1'b0;
            end else if (c_ff == "-" && !neof_ff && nb_ff >= "1" && nb_ff <= "9") begin
               mode_in = astok_pkg::MODE_DEC; mag_in = '0; neg_in = 1'b1;
               col_in = col_inc; status.done = 1'b1;
            end else begin
               mode_in = c_space ? astok_pkg::MODE_WS : astok_pkg::MODE_OTHER;
            end
         end
         astok_pkg::MODE_IDENT: begin
            if (!eof_ff && (c_word || c_digit)) begin
               wr_en = 1'b1; col_in = col_inc; status.done = 1'b1;
            end else begin
               status.emit_text = 1'b1; status.kind = astok_pkg::TOK_IDENT;
               len_in = '0; ovf_in = 1'b0; mode_in = astok_pkg::MODE_NEUTRAL;
            end
         end
         astok_pkg::MODE_STRING: begin
            status.done = 1'b1;
            if (eof_ff) begin
               status.emit = 1'b1; status.kind = astok_pkg::TOK_ERROR;
               tok_col = col_ff;
               mode_in = astok_pkg::MODE_NEUTRAL; line_in = 16'd1; col_in = 16'd1;
               start_in = 16'd1; len_in = '0; ovf_in = 1'b0; mag_in = '0; neg_in = 1'b0;
            end else if (c_ff == 8'h27 && !neof_ff && nb_ff == 8'h27) begin
               wr_en = 1'b1; col_in = col_inc; mode_in = astok_pkg::MODE_STR_ESC;
            end else if (c_ff == 8'h27) begin
               status.emit_text = 1'b1; status.kind = astok_pkg::TOK_STRING;
               len_in = '0; ovf_in = 1'b0; mode_in = astok_pkg::MODE_NEUTRAL;
               col_in = col_inc;
            end else begin
               wr_en = 1'b1; col_in = col_inc;
            end
         end
         astok_pkg::MODE_STR_ESC: begin
            col_in = col_inc; mode_in = astok_pkg::MODE_STRING; status.done = 1'b1;
         end
         astok_pkg::MODE_DEC, astok_pkg::MODE_HEX: begin
            if (!eof_ff && ((mode_ff == astok_pkg::MODE_DEC) ? c_digit : c_hex)) begin
               mag_in = mag_sum; col_in = col_inc; status.done = 1'b1;
            end else begin
               status.emit = 1'b1; status.kind = astok_pkg::TOK_INTEGER;
               mag_in = '0; neg_in = 1'b0; mode_in = astok_pkg::MODE_NEUTRAL;
            end
         end
         astok_pkg::MODE_WS: begin
            if (eof_ff || c_ff == 8'h0A) begin
               status.emit = 1'b1; status.done = 1'b1; status.nl_kind = 2'd1;
               line_in = line_inc; col_in = 16'd1; mode_in = astok_pkg::MODE_NEUTRAL;
            end else if (c_ff == ";" || c_space) begin
               if (c_ff == ";") mode_in = astok_pkg::MODE_WS_SEMI;
               col_in = col_inc; status.done = 1'b1;
            end else begin
               status.emit = 1'b1; status.kind = astok_pkg::TOK_SPACE;
               mode_in = astok_pkg::MODE_NEUTRAL;
            end
         end
         astok_pkg::MODE_OTHER, astok_pkg::MODE_SEMI, astok_pkg::MODE_WS_SEMI: begin
            if (eof_ff || c_ff == 8'h0A) begin
               status.emit = 1'b1; mode_in = astok_pkg::MODE_NEUTRAL;
               if (mode_ff == astok_pkg::MODE_OTHER) begin
                  status.kind = astok_pkg::TOK_OTHER;
               end else begin
                  status.nl_kind = (mode_ff == astok_pkg::MODE_SEMI) ? 2'd2 : 2'd3;
                  line_in = line_inc; col_in = 16'd1; status.done = 1'b1;
               end
            end else begin
               col_in = col_inc; status.done = 1'b1;
            end
         end
         default: mode_in = astok_pkg::MODE_NEUTRAL;
      endcase
      if (wr_en) begin
         if (len_ff < astok_pkg::LenW'(astok_pkg::MaxText)) len_in = len_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      // a token that leaves the item pending is followed by a neutral pass, which
      // only puts out a result for end of text, newline, comma or equals
      status.run_end = status.done ||
                       !(eof_ff || c_ff == 8'h0A || c_ff == "," || c_ff == "=");
   end

   // text buffer and first-four-byte copy for register name matching
   always_ff @(posedge clock) begin
      if (cmd.step && wr_en && len_ff < astok_pkg::LenW'(astok_pkg::MaxText)) begin
         store_mem[len_ff[astok_pkg::AddrW-1:0]] <= c_ff;
         if (len_ff == 6'd0) g0_ff <= c_ff;
         if (len_ff == 6'd1) r1_ff <= c_ff;
         if (len_ff == 6'd2) d2_ff <= c_ff;
         if (len_ff == 6'd3) d3_ff <= c_ff;
      end
      // hold the read data while the result waits
      if (cmd.text_start) rd_data_ff <= store_mem[{astok_pkg::AddrW{1'b0}}];
      else if (cmd.text_adv) rd_data_ff <= store_mem[rd_ff[astok_pkg::AddrW-1:0]];
   end

   always_comb begin
      reg_num = 5'd16;
      if (!ovf_ff && g0_ff == "G" && r1_ff == "R") begin
         if (len_ff == 6'd3 && d2_ff >= "0" && d2_ff <= "9") reg_num = {1'b0, d2_ff[3:0]};
         else if (len_ff == 6'd4 && d2_ff == "1" && d3_ff >= "0" && d3_ff <= "5")
            reg_num = 5'd10 + {1'b0, d3_ff[3:0]};
      end
   end

   assign text_last = (len_ff == '0) || (rd_ff == len_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_ff <= in_byte; eof_ff <= in_end; nb_ff <= in_next; neof_ff <= in_next_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= astok_pkg::MODE_NEUTRAL;
         line_ff <= 16'd1; col_ff <= 16'd1; start_ff <= 16'd1;
         len_ff <= '0; mag_ff <= '0; neg_ff <= 1'b0; ovf_ff <= 1'b0;
         rd_ff <= '0;
      end else begin
         if (cmd.step) begin
            mode_ff <= mode_in; line_ff <= line_in; col_ff <= col_in;
            start_ff <= start_in; len_ff <= len_in; mag_ff <= mag_in;
            neg_ff <= neg_in; ovf_ff <= ovf_in;
         end
         // read pointer runs one ahead of the registered read data
         if (cmd.text_start) rd_ff <= 6'd1;
         else if (cmd.text_adv) rd_ff <= rd_ff + 1'b1;
      end
   end

   always_comb begin
      result = '0;
      result.token_kind      = status.kind;
      result.newline_kind    = status.nl_kind;
      result.line            = line_ff;
      result.column          = tok_col;
      result.register_number = 5'd16;
      if (status.kind == astok_pkg::TOK_INTEGER) result.int_value = int_val;
      if (status.emit_text) begin
         result.text_truncated = ovf_ff;
         if (status.kind == astok_pkg::TOK_IDENT) result.register_number = reg_num;
         if (len_ff != '0) begin
            result.text_byte  = rd_data_ff;
            result.text_valid = 1'b1;
         end
      end
   end

endmodule

@@ hw/rtl/assembly_source_tokenizer_unit.sv @@
// Top level of the assembly source tokenizer.
`timescale 1ns / 1ps
// Takes one source byte per item with a byte of lookahead and end-of-text
// flags, and streams tokens out one result at a time. An item is captured
// and then stepped through its lexer passes; a pass that ends an
// identifier or string then streams one result per text byte (read from
// the text buffer, one port), and an empty string puts out a single
// result. A new item is taken only once the last one is through. A
// result that waits on rsp_tready stalls the item. An output register holds
// the latest result.
module assembly_source_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // byte_req[7:0], at_end[8], next_byte[16:9], next_at_end[17], zero fill
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // token_kind[3:0], newline_kind[5:4], line[21:6], column[37:22],
   // int_value[69:38], register_number[74:70], text_byte[82:75],
   // text_valid[83], text_truncated[84], zero fill
   output logic [87:0] rsp_tdata,
   // run_last
   output logic        rsp_tuser,
   // token_last
   output logic        rsp_tlast
);

   astok_pkg::status_type  status;
   astok_pkg::command_type cmd;
   astok_pkg::result_type  result;
   logic text_last, out_load, tok_last, run_last, out_free;
   logic valid_ff;
   logic [84:0] data_ff;
   logic tlast_ff, tuser_ff;

   assign out_free = !valid_ff || rsp_tready;

   astok_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .status, .text_last, .out_free, .out_load,
      .out_tok_last(tok_last), .out_run_last(run_last), .cmd
   );

   astok_datapath u_dp (
      .clock, .reset, .cmd,
      .in_byte(req_tdata[7:0]), .in_end(req_tdata[8]),
      .in_next(req_tdata[16:9]), .in_next_end(req_tdata[17]),
      .status, .text_last, .result
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         data_ff  <= {result.text_truncated, result.text_valid, result.text_byte,
                      result.register_number, result.int_value, result.column,
                      result.line, result.newline_kind, result.token_kind};
         tlast_ff <= tok_last;
         tuser_ff <= run_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'd0, data_ff};
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = tuser_ff;

endmodule

@@ hw/rtl/astok_checker.sv @@
// Port-level checks for the tokenizer, bound to the top level.
`timescale 1ns / 1ps
module astok_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_runlast_toklast: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("run ends inside a token");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while busy");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[3:0] <= 4'd8)
      else $error("bad token kind");

endmodule

bind assembly_source_tokenizer_unit astok_checker u_astok_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the assembly source tokenizer unit.
`timescale 1ns / 1ps
module testbench;

   localparam int WatchLimit = 20000;

   typedef struct {
      logic [87:0] data;
      logic        tok_last;
      logic        item_last;
   } token_beat_type;

   class token_scoreboard;
      token_beat_type pending[$];
      int          errors;
      int          checked;
      astok_pkg::mode_type mode;
      logic [15:0] line_no, col_no, tok_col;
      logic [7:0]  text_buf[astok_pkg::MaxText];
      int          text_len;
      bit          text_cut;
      logic [31:0] magnitude;
      bit          negative;

      function new();
         errors = 0;
         checked = 0;
         clear_state();
      endfunction

      function void clear_state();
         mode = astok_pkg::MODE_NEUTRAL;
         line_no = 1;
         col_no = 1;
         tok_col = 1;
         text_len = 0;
         text_cut = 0;
         magnitude = 0;
         negative = 0;
      endfunction

      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_space(logic [7:0] c);
         return c == " " || (c >= 8'd9 && c <= 8'd13);
      endfunction

      function void push(astok_pkg::tok_kind_type kind, logic [1:0] nlk, logic [15:0] col,
                         logic [31:0] val, logic [4:0] regn, logic [7:0] tb,
                         bit tv, bit last);
         astok_pkg::result_type r;
         token_beat_type b;
         r.token_kind = kind;
         r.newline_kind = nlk;
         r.line = line_no;
         r.column = col;
         r.int_value = val;
         r.register_number = regn;
         r.text_byte = tb;
         r.text_valid = tv;
         r.text_truncated = (kind == astok_pkg::TOK_IDENT || kind == astok_pkg::TOK_STRING)
                            ? text_cut : 1'b0;
         // first field in the lowest bits, as on rsp_tdata
         b.data = {3'b000, r.text_truncated, r.text_valid, r.text_byte, r.register_number,
                   r.int_value, r.column, r.line, r.newline_kind, r.token_kind};
         b.tok_last = last;
         b.item_last = 0;
         pending.insert(pending.size(), b);
      endfunction

      function void keep_byte(logic [7:0] c);
         if (text_len < astok_pkg::MaxText) begin
            text_buf[text_len] = c;
            text_len++;
         end else begin
            text_cut = 1;
         end
      endfunction

      function logic [4:0] gr_number();
         if (text_cut || text_len < 3 || text_len > 4) return 5'd16;
         if (text_buf[0] != "G" || text_buf[1] != "R") return 5'd16;
         if (text_len == 3) return is_digit(text_buf[2]) ? 5'(text_buf[2] - "0") : 5'd16;
         if (text_buf[2] == "1" && text_buf[3] >= "0" && text_buf[3] <= "5")
            return 5'd10 + 5'(text_buf[3] - "0");
         return 5'd16;
      endfunction

      function void flush_text(astok_pkg::tok_kind_type kind);
         logic [4:0] regn;
         regn = (kind == astok_pkg::TOK_IDENT) ? gr_number() : 5'd16;
         if (text_len == 0) begin
            push(kind, 0, tok_col, 0, regn, 0, 0, 1);
         end else begin
            for (int i = 0; i < text_len; i++)
               push(kind, 0, tok_col, 0, regn, text_buf[i], 1, i + 1 == text_len);
         end
         text_len = 0;
         text_cut = 0;
      endfunction

      function void add_digit(int base, logic [7:0] c);
         logic [63:0] m;
         logic [31:0] d;
         d = is_digit(c) ? 32'(c - "0") : 32'(c - "A" + 10);
         m = 64'(magnitude) * base + d;
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         magnitude = m[31:0];
      endfunction

      function void flush_number();
         logic [31:0] v;
         if (negative) v = (magnitude >= 32'h8000_0000) ? 32'h8000_0000 : -magnitude;
         else v = (magnitude > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : magnitude;
         push(astok_pkg::TOK_INTEGER, 0, tok_col, v, 5'd16, 0, 0, 1);
         magnitude = 0;
         negative = 0;
      endfunction

      // Run the lexer over one accepted item and queue the tokens it yields.
      function void note_item(logic [7:0] c, bit eof, logic [7:0] nb, bit neof);
         bit done;
         int passes;
         int first_new;
         done = 0;
         passes = 0;
         first_new = pending.size();
         while (!done && passes < 8) begin
            passes++;
            case (mode)
               astok_pkg::MODE_NEUTRAL: begin
                  if (eof || c == "\n") begin
                     push(astok_pkg::TOK_NEWLINE, 0, col_no, 0, 5'd16, 0, 0, 1);
                     line_no = bump(line_no);
                     col_no = 1;
                     done = 1;
                  end else if (c == "," || c == "=") begin
                     push(c == "," ? astok_pkg::TOK_COMMA : astok_pkg::TOK_EQUAL, 0, col_no,
                          0, 5'd16, 0, 0, 1);
                     col_no = bump(col_no);
                     done = 1;
                  end else if (c == ";" || c == "'" || c == "#") begin
                     mode = (c == ";") ? astok_pkg::MODE_SEMI :
                            (c == "#") ? astok_pkg::MODE_HEX : astok_pkg::MODE_STRING;
                     tok_col = col_no;
                     text_len = 0;
                     text_cut = 0;
                     magnitude = 0;
                     negative = 0;
                     col_no = bump(col_no);
                     done = 1;
                  end else if (c == "_" || c == "@" || is_alpha(c)) begin
                     mode = astok_pkg::MODE_IDENT;
                     tok_col = col_no;
                     text_len = 0;
                     text_cut = 0;
                  end else if (is_digit(c)) begin
                     mode = astok_pkg::MODE_DEC;
                     tok_col = col_no;
                     magnitude = 0;
                     negative = 0;
                  end else if (c == "-" && !neof && nb >= "1" && nb <= "9") begin
                     mode = astok_pkg::MODE_DEC;
                     tok_col = col_no;
                     magnitude = 0;
                     negative = 1;
                     col_no = bump(col_no);
                     done = 1;
                  end else begin
                     mode = is_space(c) ? astok_pkg::MODE_WS : astok_pkg::MODE_OTHER;
                     tok_col = col_no;
                  end
               end
               astok_pkg::MODE_IDENT: begin
                  if (!eof && (c == "_" || c == "@" || is_alpha(c) || is_digit(c))) begin
                     keep_byte(c);
                     col_no = bump(col_no);
                     done = 1;
                  end else begin
                     flush_text(astok_pkg::TOK_IDENT);
                     mode = astok_pkg::MODE_NEUTRAL;
                  end
               end
               astok_pkg::MODE_STRING: begin
                  if (eof) begin
                     push(astok_pkg::TOK_ERROR, 0, col_no, 0, 5'd16, 0, 0, 1);
                     clear_state();
                     done = 1;
                  end else if (c == "'" && !neof && nb == "'") begin
                     keep_byte("'");
                     col_no = bump(col_no);
                     mode = astok_pkg::MODE_STR_ESC;
                     done = 1;
                  end else if (c == "'") begin
                     flush_text(astok_pkg::TOK_STRING);
                     mode = astok_pkg::MODE_NEUTRAL;
                     col_no = bump(col_no);
                     done = 1;
                  end else begin
                     keep_byte(c);
                     col_no = bump(col_no);
                     done = 1;
                  end
               end
               astok_pkg::MODE_STR_ESC: begin
                  col_no = bump(col_no);
                  mode = astok_pkg::MODE_STRING;
                  done = 1;
               end
               astok_pkg::MODE_DEC, astok_pkg::MODE_HEX: begin
                  if (!eof && mode == astok_pkg::MODE_DEC && is_digit(c)) begin
                     add_digit(10, c);
                     col_no = bump(col_no);
                     done = 1;
                  end else if (!eof && mode == astok_pkg::MODE_HEX &&
                               (is_digit(c) || (c >= "A" && c <= "F"))) begin
                     add_digit(16, c);
                     col_no = bump(col_no);
                     done = 1;
                  end else begin
                     flush_number();
                     mode = astok_pkg::MODE_NEUTRAL;
                  end
               end
               astok_pkg::MODE_WS: begin
                  if (eof || c == "\n") begin
                     push(astok_pkg::TOK_NEWLINE, 1, tok_col, 0, 5'd16, 0, 0, 1);
                     line_no = bump(line_no);
                     col_no = 1;
                     mode = astok_pkg::MODE_NEUTRAL;
                     done = 1;
                  end else if (c == ";" || is_space(c)) begin
                     if (c == ";") mode = astok_pkg::MODE_WS_SEMI;
                     col_no = bump(col_no);
                     done = 1;
                  end else begin
                     push(astok_pkg::TOK_SPACE, 0, tok_col, 0, 5'd16, 0, 0, 1);
                     mode = astok_pkg::MODE_NEUTRAL;
                  end
               end
               astok_pkg::MODE_OTHER, astok_pkg::MODE_SEMI, astok_pkg::MODE_WS_SEMI: begin
                  if (eof || c == "\n") begin
                     if (mode == astok_pkg::MODE_OTHER) begin
                        push(astok_pkg::TOK_OTHER, 0, tok_col, 0, 5'd16, 0, 0, 1);
                     end else begin
                        push(astok_pkg::TOK_NEWLINE,
                             mode == astok_pkg::MODE_SEMI ? 2'd2 : 2'd3, tok_col,
                             0, 5'd16, 0, 0, 1);
                        line_no = bump(line_no);
                        col_no = 1;
                        done = 1;
                     end
                     mode = astok_pkg::MODE_NEUTRAL;
                  end else begin
                     col_no = bump(col_no);
                     done = 1;
                  end
               end
               default: mode = astok_pkg::MODE_NEUTRAL;
            endcase
         end
         if (pending.size() > first_new) pending[$].item_last = 1;
      endfunction

      function void check_token(logic [87:0] data, bit tok_last, bit item_last);
         token_beat_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result data=%h last=%b user=%b",
                     $time, data, tok_last, item_last);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.data !== data || e.tok_last !== tok_last || e.item_last !== item_last) begin
            $display("%0t: mismatch expected data=%h last=%b user=%b", $time,
                     e.data, e.tok_last, e.item_last);
            $display("%0t:          actual   data=%h last=%b user=%b", $time,
                     data, tok_last, item_last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   token_scoreboard lexer_sb;
   logic [7:0]      source_text[$];
   bit              source_end[$];
   bit              feed_done;
   bit              rsp_hold;
   int              idle_cycles;

   assembly_source_tokenizer_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   task automatic add_byte(logic [7:0] c, bit e);
      source_text.insert(source_text.size(), c);
      source_end.insert(source_end.size(), e);
   endtask

   task automatic add_line(string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i], 0);
      end
   endtask

   task automatic add_end();
      add_byte(8'($urandom), 1);
   endtask

   function automatic string pick_word();
      string w;
      int n;
      case ($urandom_range(0, 9))
         0: return $sformatf("GR%0d", $urandom_range(0, 15));
         1: return $sformatf("GR%0d", $urandom_range(16, 99));
         2: return "LAD";
         3: return $sformatf("%0d", $urandom);
         4: return $sformatf("-%0d", $urandom_range(1, 99999));
         5: return $sformatf("#%0h", $urandom);
         6: return $sformatf("#%0H", $urandom_range(0, 65535));
         default: begin
            w = "";
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               w = {w, string'(8'($urandom_range("A", "Z")))};
            return w;
         end
      endcase
   endfunction

   task automatic build_random(int count);
      string s;
      int r;
      while (source_text.size() < count) begin
         r = $urandom_range(0, 19);
         if (r < 12) begin
            s = {pick_word(), " ", pick_word(), ",", pick_word(), "=", pick_word()};
            if ($urandom_range(0, 2) == 0) s = {s, " ; note"};
            if ($urandom_range(0, 3) == 0) s = {s, " 'it''s'"};
            if ($urandom_range(0, 4) == 0) s = {"\t", s, " "};
            add_line({s, "\n"});
         end else if (r < 15) begin
            s = "'";
            for (int i = 0; i < $urandom_range(0, 40); i++)
               s = {s, string'(8'($urandom_range(32, 126) == 39 ? 65 : $urandom_range(32, 126)))};
            add_line({s, "'\n"});
         end else if (r < 18) begin
            // noise, high bytes included
            for (int i = 0; i < $urandom_range(1, 8); i++) begin
               add_byte(8'($urandom), 0);
            end
         end else if (r == 18) begin
            add_line("'open");
            add_end();
         end else begin
            add_end();
         end
      end
   endtask

   task automatic feed_source();
      logic [7:0] nb;
      bit         ne;
      int         gap;
      for (int i = 0; i < source_text.size(); i++) begin
         gap = $urandom_range(0, 11);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         if (i + 1 < source_text.size()) begin
            nb = source_text[i + 1];
            ne = source_end[i + 1];
         end else begin
            nb = 8'($urandom);
            ne = 1;
         end
         req_tvalid <= 1;
         req_tdata <= {6'd0, ne, nb, source_end[i], source_text[i]};
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         lexer_sb.note_item(source_text[i], source_end[i], nb, ne);
      end
      req_tvalid <= 0;
      feed_done = 1;
   endtask

   // Long back-pressure window early in the run.
   initial begin
      rsp_hold = 0;
      @(negedge reset);
      repeat (200) @(posedge clock);
      rsp_hold = 1;
      repeat (400) @(posedge clock);
      rsp_hold = 0;
   end

   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         gap = $urandom_range(0, 11);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0 || rsp_hold) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         lexer_sb.check_token(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("watchdog expired with %0d results outstanding",
                     lexer_sb.pending.size());
            $display("** assembly_source_tokenizer_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      lexer_sb = new();
      feed_done = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      add_line("LD GR0,GR15\n");
      add_line(" ;x\n;y\n'a''b',=-7 -x #7FFFFFFF1\n#,99999999999 -2147483649\n");
      add_line("_@z\xff\x80 #G GR16 gr1 ");
      add_end();
      add_line("ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghij\n");
      add_line("''\n");
      build_random(280);
      add_line("'unterminated");
      add_end();
      add_line("A");
      add_end();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      feed_source();
      while (lexer_sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("fed %0d source bytes, checked %0d token results",
               source_text.size(), lexer_sb.checked);
      $display("covered all token kinds, long text, register names and open strings");
      if (lexer_sb.errors == 0 && lexer_sb.pending.size() == 0) begin
         $display("** assembly_source_tokenizer_unit: PASSED **");
      end else begin
         $display("** assembly_source_tokenizer_unit: FAILED **");
      end
      $finish;
   end
endmodule
